### hw/rtl/hlr_pkg.sv
// Package for the histogram largest-rectangle block.
// Sizes, queue entry and stack entry types, engine state codes.
// No dependencies.
package hlr_pkg;

  localparam int MAX_BARS    = 65536;
  localparam int HEIGHT_BITS = 32;
  localparam int IN_HEIGHT_W = 32;
  localparam int AREA_W      = 48;
  localparam int IDX_W       = $clog2(MAX_BARS);
  localparam int CNT_W       = $clog2(MAX_BARS + 1);
  localparam int PROD_W      = HEIGHT_BITS + CNT_W;
  localparam int EXT_W       = (PROD_W > AREA_W) ? PROD_W : AREA_W + 1;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

  typedef logic [HEIGHT_BITS-1:0] height_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [AREA_W-1:0]      area_t;
  typedef logic [PROD_W-1:0]      prod_t;

  localparam area_t AREA_MAX = {AREA_W{1'b1}};

  // One classified bar, as handed from the front to the stack engine.
  typedef struct packed {
    height_t height;
    idx_t    idx;    // bar position, valid when keep
    cnt_t    count;  // bar count after this bar (flush boundary)
    logic    keep;   // bar fits in capacity
    logic    last;
    logic    ovf;    // overflow seen so far in this histogram
  } item_t;

  typedef struct packed {
    idx_t    idx;
    height_t height;
  } stack_ent_t;

  localparam int STACK_W = $bits(stack_ent_t);

  typedef enum logic [1:0] {
    ST_DISPATCH,
    ST_POP,
    ST_DONE
  } eng_state_t;

endpackage

### hw/rtl/histogram_largest_rectangle.sv
// Largest rectangle under a histogram. A bar transaction goes into the queue; the
// engine pops any taller stacked entries, each pop a stack RAM read and then a
// multiply, and then pushes the bar if it is kept. The last bar flushes the stack
// with one pop per stacked entry before the result closes out. The engine takes
// another bar from the queue only once the pops of the last one are done. Sync
// active-low reset empties stack and queue; stack RAM contents are not cleared.
// Depends on hlr_pkg, hlr_front, hlr_fifo, hlr_engine.
module histogram_largest_rectangle (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hlr_pkg::IN_HEIGHT_W-1:0]  in_height,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hlr_pkg::AREA_W-1:0]       out_max_area,
  output logic                             out_overflow
);

  // Front classifies each bar (kept or dropped for capacity), tags it with its
  // position and the running bar count, and tracks overflow per histogram.
  logic           q_push, q_full, q_pop, q_head_valid;
  hlr_pkg::item_t q_data, q_head;

  hlr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_height (in_height),
    .in_last   (in_last),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  // Queue lets the front keep taking bars while the engine pops.
  hlr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Engine runs the monotonic stack: the top entry lives in registers, the rest in
  // RAM. A shorter bar pops and scores taller entries; the last bar flushes the
  // stack and the maximum goes to the output register.
  hlr_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (q_head_valid),
    .head         (q_head),
    .head_pop     (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_max_area (out_max_area),
    .out_overflow (out_overflow)
  );

endmodule

### hw/rtl/hlr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/hlr_fifo.sv
// Short queue of classified bars between the front and the stack engine.
// Depends on hlr_pkg.
module hlr_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hlr_pkg::item_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output hlr_pkg::item_t head
);

  hlr_pkg::item_t                     mem_r [hlr_pkg::FIFO_DEPTH];
  logic [hlr_pkg::FIFO_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [hlr_pkg::FIFO_PTR_W:0]       count_r;
  logic                               do_push, do_pop;

  assign full       = (count_r == (hlr_pkg::FIFO_PTR_W+1)'(hlr_pkg::FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/hlr_front.sv
// Input front: takes bar transactions, counts bars, flags overflow.
// Depends on hlr_pkg.
module hlr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hlr_pkg::IN_HEIGHT_W-1:0]     in_height,
  input  logic                                in_last,
  input  logic                                q_full,
  output logic                                q_push,
  output hlr_pkg::item_t                      q_data
);

  hlr_pkg::cnt_t cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          keep;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign keep     = (cnt_r < hlr_pkg::CNT_W'(hlr_pkg::MAX_BARS));

  always_comb begin
    q_data.height = hlr_pkg::height_t'(in_height);
    q_data.idx    = cnt_r[hlr_pkg::IDX_W-1:0];
    q_data.count  = keep ? cnt_r + 1'b1 : cnt_r;
    q_data.keep   = keep;
    q_data.last   = in_last;
    q_data.ovf    = ovf_r || !keep;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (q_push) begin
      if (in_last) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        cnt_nxt = q_data.count;
        ovf_nxt = q_data.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

### hw/rtl/hlr_engine.sv
// Stack engine: monotonic stack push/pop/score, flush and result register.
// Depends on hlr_pkg and hlr_ram.
module hlr_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  hlr_pkg::item_t                head,
  output logic                          head_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hlr_pkg::AREA_W-1:0]    out_max_area,
  output logic                          out_overflow
);

  hlr_pkg::eng_state_t state_r, state_nxt;
  hlr_pkg::cnt_t       sp_r, sp_nxt;
  hlr_pkg::stack_ent_t top_r, top_nxt;
  logic                flushing_r, flushing_nxt;
  hlr_pkg::area_t      best_r, best_nxt;
  hlr_pkg::prod_t      area_r, area_nxt;
  logic                area_v_r, area_v_nxt;
  logic                out_valid_r, out_valid_nxt;
  hlr_pkg::area_t      out_area_r, out_area_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic                         ram_we;
  hlr_pkg::stack_ent_t          ram_wdata, ram_rdata;
  logic [hlr_pkg::STACK_W-1:0]  ram_rbits;
  hlr_pkg::cnt_t                sp_m2, pos, width;
  logic [hlr_pkg::EXT_W-1:0]    area_ext;
  hlr_pkg::area_t               area_sat;

  hlr_ram #(
    .WIDTH (hlr_pkg::STACK_W),
    .DEPTH (hlr_pkg::MAX_BARS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sp_r[hlr_pkg::IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (sp_m2[hlr_pkg::IDX_W-1:0]),
    .rdata (ram_rbits)
  );

  assign ram_rdata = hlr_pkg::stack_ent_t'(ram_rbits);
  assign ram_wdata = '{idx: head.idx, height: head.height};
  // entry below the top, fetched while deciding to pop
  assign sp_m2     = sp_r - hlr_pkg::CNT_W'(2);
  assign pos       = flushing_r ? head.count : hlr_pkg::CNT_W'(head.idx);
  assign width     = (sp_r == hlr_pkg::CNT_W'(1)) ? pos
                   : pos - hlr_pkg::CNT_W'(1) - hlr_pkg::CNT_W'(ram_rdata.idx);
  assign area_ext  = hlr_pkg::EXT_W'(area_r);
  assign area_sat  = (area_ext > hlr_pkg::EXT_W'(hlr_pkg::AREA_MAX)) ? hlr_pkg::AREA_MAX
                   : area_ext[hlr_pkg::AREA_W-1:0];

  assign out_valid    = out_valid_r;
  assign out_max_area = out_area_r;
  assign out_overflow = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    top_nxt       = top_r;
    flushing_nxt  = flushing_r;
    best_nxt      = best_r;
    area_nxt      = area_r;
    area_v_nxt    = 1'b0;
    out_valid_nxt = out_valid_r;
    out_area_nxt  = out_area_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    head_pop      = 1'b0;

    // fold the score of the previous pop into the running maximum
    if (area_v_r && (area_sat > best_r)) begin
      best_nxt = area_sat;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      hlr_pkg::ST_DISPATCH: begin
        if (head_valid) begin
          priority if (flushing_r) begin
            state_nxt = (sp_r != '0) ? hlr_pkg::ST_POP : hlr_pkg::ST_DONE;
          end else if (head.keep && (sp_r != '0) && (head.height < top_r.height)) begin
            state_nxt = hlr_pkg::ST_POP;
          end else begin
            if (head.keep) begin
              ram_we  = 1'b1;
              top_nxt = ram_wdata;
              sp_nxt  = sp_r + 1'b1;
            end
            if (head.last) begin
              flushing_nxt = 1'b1;
            end else begin
              head_pop = 1'b1;
            end
          end
        end
      end
      hlr_pkg::ST_POP: begin
        area_nxt   = top_r.height * width;
        area_v_nxt = 1'b1;
        top_nxt    = ram_rdata;
        sp_nxt     = sp_r - 1'b1;
        state_nxt  = hlr_pkg::ST_DISPATCH;
      end
      hlr_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_area_nxt  = best_r;
          out_ovf_nxt   = head.ovf;
          best_nxt      = '0;
          sp_nxt        = '0;
          flushing_nxt  = 1'b0;
          head_pop      = 1'b1;
          state_nxt     = hlr_pkg::ST_DISPATCH;
        end
      end
      default: state_nxt = hlr_pkg::ST_DISPATCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hlr_pkg::ST_DISPATCH;
      sp_r        <= '0;
      flushing_r  <= 1'b0;
      best_r      <= '0;
      area_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      flushing_r  <= flushing_nxt;
      best_r      <= best_nxt;
      area_v_r    <= area_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    area_r     <= area_nxt;
    out_area_r <= out_area_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule

### hw/rtl/hlr_checker.sv
// Port-level checker for histogram_largest_rectangle, bound to the top level.
// Depends on hlr_pkg.
module hlr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_last,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [hlr_pkg::AREA_W-1:0]      out_max_area,
  input logic                            out_overflow
);

  // histograms closed at the input but not yet delivered
  logic [3:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'((in_valid && in_ready && in_last) ? 1 : 0)
                       - 4'((out_valid && out_ready) ? 1 : 0);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_max_area) && $stable(out_overflow))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without a closed histogram");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'(hlr_pkg::FIFO_DEPTH + 2))
    else $error("more histograms in flight than the queue holds");

endmodule

bind histogram_largest_rectangle hlr_checker u_hlr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_last      (in_last),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_max_area (out_max_area),
  .out_overflow (out_overflow)
);
